// ===== rtl/core/bqe_pkg.sv =====
// shared types, code words and constant tables of the quantizing zigzag coder
// no dependencies
package bqe_pkg;

   localparam int BLOCK_SIZE = 64;
   localparam int QW = 9;
   localparam int SYM_DW = 15;

   localparam logic FUNC_FLUSH = 1'b1;
   localparam logic [8:0] Q_POS_MAX = 9'd255;
   localparam logic [8:0] Q_NEG_MIN = 9'h100;

   localparam logic [3:0] CODE_EOB = 4'b1010;
   localparam logic [3:0] CODE_LONG = 4'b1011;
   localparam logic [2:0] CODE_MEDIUM = 3'b100;
   localparam logic [1:0] CODE_PAIR = 2'b00;
   localparam logic [1:0] CODE_SHORT = 2'b01;
   localparam logic [1:0] CODE_RUN = 2'b11;

   localparam logic [3:0] LEN_EOB = 4'd4;
   localparam logic [3:0] LEN_RUN = 4'd5;
   localparam logic [3:0] LEN_PAIR = 4'd8;
   localparam logic [3:0] LEN_SHORT = 4'd5;
   localparam logic [3:0] LEN_MEDIUM = 4'd9;
   localparam logic [3:0] LEN_LONG = 4'd13;
   localparam logic [3:0] LEN_FLUSH = 4'd15;

   localparam logic [2:0] SHIFT_TAB [0:1][0:14] = '{
      '{3'd3, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5,
        3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6},
      '{3'd3, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3,
        3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5}
   };

   // zigzag position to raster index
   localparam logic [5:0] ZZ_ORDER [0:63] = '{
       6'd0,  6'd1,  6'd8, 6'd16,  6'd9,  6'd2,  6'd3, 6'd10,
      6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11,  6'd4,  6'd5,
      6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
      6'd27, 6'd20, 6'd13,  6'd6,  6'd7, 6'd14, 6'd21, 6'd28,
      6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
      6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
      6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
      6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
   };

   // raster index to zigzag position
   localparam logic [5:0] ZZ_INV [0:63] = '{
       6'd0,  6'd1,  6'd5,  6'd6, 6'd14, 6'd15, 6'd27, 6'd28,
       6'd2,  6'd4,  6'd7, 6'd13, 6'd16, 6'd26, 6'd29, 6'd42,
       6'd3,  6'd8, 6'd12, 6'd17, 6'd25, 6'd30, 6'd41, 6'd43,
       6'd9, 6'd11, 6'd18, 6'd24, 6'd31, 6'd40, 6'd44, 6'd53,
      6'd10, 6'd19, 6'd23, 6'd32, 6'd39, 6'd45, 6'd52, 6'd54,
      6'd20, 6'd22, 6'd33, 6'd38, 6'd46, 6'd51, 6'd55, 6'd60,
      6'd21, 6'd34, 6'd37, 6'd47, 6'd50, 6'd56, 6'd59, 6'd61,
      6'd35, 6'd36, 6'd48, 6'd49, 6'd57, 6'd58, 6'd62, 6'd63
   };

   typedef struct packed {
      logic vld;
      logic [5:0] addr;
      logic [QW-1:0] data;
   } wr_type;

   typedef struct packed {
      logic flush;
      logic [6:0] last_cnt;
   } cmd_type;

   typedef struct packed {
      logic vld;
      logic fin;
      logic [3:0] len;
      logic [SYM_DW-1:0] data;
   } sym_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_FLUSH,
      BK_RUN,
      BK_FIN
   } back_state_type;

endpackage

// ===== rtl/core/bqe_front.sv =====
// front part: accepts requests, quantizes coefficients and queues commands
// depends on bqe_pkg
module bqe_front #(
   parameter int COEFF_WIDTH = 16,
   parameter int FRAC_BITS = 3
) (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  logic func,
   input  logic [COEFF_WIDTH-1:0] coeff,
   input  logic quant_select,
   output bqe_pkg::wr_type wr,
   output logic push,
   output bqe_pkg::cmd_type push_cmd
);

   localparam int MW = COEFF_WIDTH + 1;
   localparam int SW = COEFF_WIDTH + 2;

   logic [5:0] load_cnt_ff, load_cnt_in;
   logic [6:0] last_cnt_ff, last_cnt_in;
   logic neg;
   logic [MW-1:0] mag;
   logic [3:0] row_col;
   logic [4:0] shift;
   logic [SW-1:0] sum, rnd;
   logic [8:0] qv;
   logic [6:0] base, pos1;
   logic load;

   assign load = accept && (func != bqe_pkg::FUNC_FLUSH);
   assign neg = coeff[COEFF_WIDTH-1];
   assign mag = neg ? (MW'(0) - {coeff[COEFF_WIDTH-1], coeff}) : {1'b0, coeff};
   assign row_col = {1'b0, load_cnt_ff[5:3]} + {1'b0, load_cnt_ff[2:0]};
   assign shift = 5'(FRAC_BITS) + {2'b00, bqe_pkg::SHIFT_TAB[quant_select][row_col]};
   assign sum = {1'b0, mag} + (SW'(1) << (shift - 5'd1));
   assign rnd = sum >> shift;

   always_comb begin
      if (neg) begin
         qv = (rnd > SW'(256)) ? bqe_pkg::Q_NEG_MIN : 9'(9'd0 - rnd[8:0]);
      end else begin
         qv = (rnd > SW'(255)) ? bqe_pkg::Q_POS_MAX : rnd[8:0];
      end
   end

   assign base = (load_cnt_ff == 6'd0) ? 7'd0 : last_cnt_ff;
   assign pos1 = {1'b0, bqe_pkg::ZZ_INV[load_cnt_ff]} + 7'd1;

   always_comb begin
      load_cnt_in = load_cnt_ff;
      last_cnt_in = last_cnt_ff;
      if (load) begin
         load_cnt_in = load_cnt_ff + 6'd1;
         last_cnt_in = ((qv != 9'd0) && (pos1 > base)) ? pos1 : base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_cnt_ff <= '0;
         last_cnt_ff <= '0;
      end else begin
         load_cnt_ff <= load_cnt_in;
         last_cnt_ff <= last_cnt_in;
      end
   end

   assign wr.vld = load;
   assign wr.addr = load_cnt_ff;
   assign wr.data = qv;

   assign push = accept && ((func == bqe_pkg::FUNC_FLUSH) || (load_cnt_ff == 6'd63));
   assign push_cmd.flush = (func == bqe_pkg::FUNC_FLUSH);
   assign push_cmd.last_cnt = last_cnt_in;

endmodule

// ===== rtl/core/bqe_cmd_fifo.sv =====
// two-entry command queue between front and back
// depends on bqe_pkg
module bqe_cmd_fifo (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  bqe_pkg::cmd_type push_cmd,
   input  logic pop,
   output logic full,
   output logic not_empty,
   output logic has_enc,
   output bqe_pkg::cmd_type head
);

   bqe_pkg::cmd_type mem_ff [0:1];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic slot_vld [0:1];

   assign full = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head = mem_ff[rp_ff];

   always_comb begin
      has_enc = 1'b0;
      for (int i = 0; i < 2; i++) begin
         slot_vld[i] = (cnt_ff == 2'd2) || ((cnt_ff == 2'd1) && (rp_ff == 1'(i)));
         if (slot_vld[i] && !mem_ff[i].flush) begin
            has_enc = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (pop) begin
            rp_ff <= ~rp_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// ===== rtl/core/bqe_back.sv =====
// back part: coefficient store, zigzag walk and variable-length code selection
// depends on bqe_pkg
module bqe_back (
   input  logic clock,
   input  logic reset,
   input  bqe_pkg::wr_type wr,
   input  logic cmd_vld,
   input  bqe_pkg::cmd_type cmd,
   output logic cmd_pop,
   output logic busy_enc,
   output bqe_pkg::sym_type sym,
   input  logic sym_ready
);

   logic [8:0] mem [0:63];
   logic [8:0] rd_q_ff;
   logic [5:0] rd_addr;

   bqe_pkg::back_state_type state_ff, state_in;
   logic [8:0] w_ff [0:2];
   logic [8:0] w_in [0:2];
   logic wa_ff [0:2];
   logic wa_in [0:2];
   logic [1:0] vc_ff, vc_in, vc_rem;
   logic pend_ff, pend_in, pabs_ff, pabs_in;
   logic [6:0] rp_ff, rp_in, k_ff, k_in, lc_ff, lc_in;
   logic [2:0] run_ff, run_in;
   logic [1:0] consume;
   logic avail, running, start, issue, eob, dec_vld;
   logic [3:0] dec_len;
   logic [14:0] dec_data;
   logic w0_zero, w0_short, w0_med, w1_short, w1_zero, w2_zero;

   assign rd_addr = bqe_pkg::ZZ_ORDER[rp_ff[5:0]];

   always_ff @(posedge clock) begin
      if (wr.vld) begin
         mem[wr.addr] <= wr.data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   assign running = (state_ff == bqe_pkg::BK_RUN);
   assign avail = running && (vc_ff == 2'd3) && sym_ready;
   assign start = (state_ff == bqe_pkg::BK_IDLE) && cmd_vld;
   assign busy_enc = running;

   assign w0_zero = (w_ff[0] == 9'd0);
   assign w0_short = (w_ff[0][8:2] == 7'h00) || (w_ff[0][8:2] == 7'h7f);
   assign w0_med = (w_ff[0][8:5] == 4'h0) || (w_ff[0][8:5] == 4'hf);
   assign w1_short = !wa_ff[1] && ((w_ff[1][8:2] == 7'h00) || (w_ff[1][8:2] == 7'h7f));
   assign w1_zero = (w_ff[1] == 9'd0);
   assign w2_zero = !wa_ff[2] && (w_ff[2] == 9'd0);

   // code selection for the coefficient at the head of the window
   always_comb begin
      consume = 2'd0;
      run_in = run_ff;
      eob = 1'b0;
      dec_vld = 1'b0;
      dec_len = '0;
      dec_data = '0;
      if (avail) begin
         if (w0_zero) begin
            if (k_ff >= lc_ff) begin
               eob = 1'b1;
               dec_vld = 1'b1;
               dec_len = bqe_pkg::LEN_EOB;
               dec_data = {11'd0, bqe_pkg::CODE_EOB};
            end else if (run_ff == 3'd7) begin
               run_in = 3'd0;
               consume = 2'd1;
               dec_vld = 1'b1;
               dec_len = bqe_pkg::LEN_RUN;
               dec_data = {10'd0, bqe_pkg::CODE_RUN, 3'd0};
            end else begin
               run_in = run_ff + 3'd1;
               consume = 2'd1;
            end
         end else if (run_ff != 3'd0) begin
            run_in = 3'd0;
            dec_vld = 1'b1;
            dec_len = bqe_pkg::LEN_RUN;
            dec_data = {10'd0, bqe_pkg::CODE_RUN, run_ff};
         end else if (w0_short) begin
            dec_vld = 1'b1;
            if (w1_short && !(w1_zero && w2_zero)) begin
               consume = 2'd2;
               dec_len = bqe_pkg::LEN_PAIR;
               dec_data = {7'd0, bqe_pkg::CODE_PAIR, w_ff[0][2:0], w_ff[1][2:0]};
            end else begin
               consume = 2'd1;
               dec_len = bqe_pkg::LEN_SHORT;
               dec_data = {10'd0, bqe_pkg::CODE_SHORT, w_ff[0][2:0]};
            end
         end else if (w0_med) begin
            consume = 2'd1;
            dec_vld = 1'b1;
            dec_len = bqe_pkg::LEN_MEDIUM;
            dec_data = {6'd0, bqe_pkg::CODE_MEDIUM, w_ff[0][5:0]};
         end else begin
            consume = 2'd1;
            dec_vld = 1'b1;
            dec_len = bqe_pkg::LEN_LONG;
            dec_data = {2'd0, bqe_pkg::CODE_LONG, w_ff[0]};
         end
      end
   end

   assign k_in = start ? 7'd0 : (k_ff + {5'd0, consume});
   assign lc_in = start ? cmd.last_cnt : lc_ff;
   assign vc_rem = vc_ff - consume;
   assign issue = running && (({1'b0, vc_rem} + {2'd0, pend_ff}) < 3'd3);

   // window refill from the store
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         w_in[j] = w_ff[j];
         wa_in[j] = wa_ff[j];
      end
      case (consume)
         2'd1: begin
            w_in[0] = w_ff[1];
            wa_in[0] = wa_ff[1];
            w_in[1] = w_ff[2];
            wa_in[1] = wa_ff[2];
         end
         2'd2: begin
            w_in[0] = w_ff[2];
            wa_in[0] = wa_ff[2];
         end
         default: begin
         end
      endcase
      vc_in = vc_rem;
      if (running && pend_ff) begin
         for (int j = 0; j < 3; j++) begin
            if (vc_rem == 2'(j)) begin
               w_in[j] = rd_q_ff;
               wa_in[j] = pabs_ff;
            end
         end
         vc_in = vc_rem + 2'd1;
      end
      pend_in = issue;
      pabs_in = rp_ff[6];
      rp_in = (issue && !rp_ff[6]) ? (rp_ff + 7'd1) : rp_ff;
      if (start) begin
         vc_in = 2'd0;
         pend_in = 1'b0;
         rp_in = 7'd0;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bqe_pkg::BK_IDLE: begin
            if (cmd_vld) begin
               state_in = cmd.flush ? bqe_pkg::BK_FLUSH : bqe_pkg::BK_RUN;
            end
         end
         bqe_pkg::BK_FLUSH: begin
            if (sym_ready) begin
               state_in = bqe_pkg::BK_FIN;
            end
         end
         bqe_pkg::BK_RUN: begin
            if (eob || (k_in == 7'd64)) begin
               state_in = bqe_pkg::BK_FIN;
            end
         end
         bqe_pkg::BK_FIN: begin
            if (sym_ready) begin
               state_in = bqe_pkg::BK_IDLE;
            end
         end
         default: state_in = bqe_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop = 1'b0;
      sym = '0;
      case (state_ff)
         bqe_pkg::BK_IDLE: begin
            cmd_pop = cmd_vld;
         end
         bqe_pkg::BK_FLUSH: begin
            sym.vld = 1'b1;
            sym.len = bqe_pkg::LEN_FLUSH;
         end
         bqe_pkg::BK_RUN: begin
            sym.vld = dec_vld;
            sym.len = dec_len;
            sym.data = dec_data;
         end
         bqe_pkg::BK_FIN: begin
            sym.vld = 1'b1;
            sym.fin = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         w_ff[j] <= w_in[j];
         wa_ff[j] <= wa_in[j];
      end
      pabs_ff <= pabs_in;
      lc_ff <= lc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bqe_pkg::BK_IDLE;
         vc_ff <= '0;
         pend_ff <= 1'b0;
         rp_ff <= '0;
         k_ff <= '0;
         run_ff <= '0;
      end else begin
         state_ff <= state_in;
         vc_ff <= vc_in;
         pend_ff <= pend_in;
         rp_ff <= rp_in;
         k_ff <= k_in;
         run_ff <= start ? 3'd0 : run_in;
      end
   end

endmodule

// ===== rtl/core/bqe_packer.sv =====
// bit packer: msb-first 16-bit words, one held word and the output register
// depends on bqe_pkg
module bqe_packer (
   input  logic clock,
   input  logic reset,
   input  bqe_pkg::sym_type sym,
   output logic sym_ready,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic rsp_tlast
);

   logic [15:0] buf_ff, buf_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [15:0] hold_ff;
   logic hold_vld_ff, hold_vld_in;
   logic out_vld_ff, out_vld_in, out_last_ff;
   logic [15:0] out_word_ff;
   logic out_free, take, produce, out_load, load_last;
   logic [30:0] acc;
   logic [4:0] tot;
   logic [15:0] word;

   assign out_free = !out_vld_ff || rsp_tready;
   assign sym_ready = !hold_vld_ff || out_free;
   assign take = sym.vld && sym_ready;

   assign acc = (31'(buf_ff) << sym.len) | 31'(sym.data);
   assign tot = {1'b0, cnt_ff} + {1'b0, sym.len};
   assign produce = tot[4];
   assign word = 16'(acc >> tot[3:0]);

   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      hold_vld_in = hold_vld_ff;
      out_load = 1'b0;
      load_last = 1'b0;
      if (take) begin
         if (sym.fin) begin
            out_load = hold_vld_ff;
            load_last = 1'b1;
            hold_vld_in = 1'b0;
         end else begin
            cnt_in = tot[3:0];
            buf_in = acc[15:0] & ((16'd1 << tot[3:0]) - 16'd1);
            if (produce) begin
               out_load = hold_vld_ff;
               hold_vld_in = 1'b1;
            end
         end
      end
      out_vld_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : out_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (take && !sym.fin && produce) begin
         hold_ff <= word;
      end
      if (out_load) begin
         out_word_ff <= hold_ff;
         out_last_ff <= load_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff <= '0;
         cnt_ff <= '0;
         hold_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         buf_ff <= buf_in;
         cnt_ff <= cnt_in;
         hold_vld_ff <= hold_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata = out_word_ff;
   assign rsp_tlast = out_last_ff;

endmodule

// ===== rtl/core/block_quantize_entropy_encode.sv =====
// Quantizing zigzag run-length coder for 8x8 blocks. Coefficients of a block arrive in
// raster order, one request per cycle while req_tready is high, and are quantized and
// stored as they come. The 64th coefficient starts the zigzag encode pass, in which the
// single read port of the coefficient store refills a three-entry window; coefficients
// of the next block are held off until the pass ends. A flush request passes through
// the flush and closing states of the back part.
// Words leave MSB first; tlast marks the last word caused by a request.
// depends on bqe_pkg, bqe_front, bqe_cmd_fifo, bqe_back, bqe_packer
module block_quantize_entropy_encode #(
   parameter int COEFF_WIDTH = 16,
   parameter int FRAC_BITS = 3
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [2:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [((COEFF_WIDTH+7)/8)*8-1:0] req_tdata,  // coeff_value
   input  logic req_tuser,                                // func
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [15:0] rsp_tdata,                         // out_word
   output logic rsp_tlast                                 // last_word
);

   logic quant_select_ff;
   logic accept;
   bqe_pkg::wr_type wr;
   logic push, pop, fifo_full, fifo_vld, fifo_has_enc, busy_enc, sym_ready;
   bqe_pkg::cmd_type push_cmd, head;
   bqe_pkg::sym_type sym;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {31'd0, quant_select_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         quant_select_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == 1'b0)) begin
         quant_select_ff <= csr_pwdata[0];
      end
   end

   assign req_tready = !fifo_full && !fifo_has_enc && !busy_enc;
   assign accept = req_tvalid && req_tready;

   bqe_front #(
      .COEFF_WIDTH(COEFF_WIDTH),
      .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .func(req_tuser),
      .coeff(req_tdata[COEFF_WIDTH-1:0]),
      .quant_select(quant_select_ff),
      .wr(wr),
      .push(push),
      .push_cmd(push_cmd)
   );

   bqe_cmd_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_cmd(push_cmd),
      .pop(pop),
      .full(fifo_full),
      .not_empty(fifo_vld),
      .has_enc(fifo_has_enc),
      .head(head)
   );

   bqe_back u_back (
      .clock(clock),
      .reset(reset),
      .wr(wr),
      .cmd_vld(fifo_vld),
      .cmd(head),
      .cmd_pop(pop),
      .busy_enc(busy_enc),
      .sym(sym),
      .sym_ready(sym_ready)
   );

   bqe_packer u_packer (
      .clock(clock),
      .reset(reset),
      .sym(sym),
      .sym_ready(sym_ready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

endmodule

// ===== tb/bqe_checker.sv =====
`timescale 1ns / 1ps
// predicts and checks the packed word stream of the zigzag coefficient coder
// watches the request, result and configuration ports; depends on bqe_pkg
module bqe_checker (
   input  logic clock,
   input  logic reset,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [2:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic csr_pready,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [15:0] req_tdata,
   input  logic req_tuser,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic rsp_tlast,
   output int fail_count,
   output int pending
);

   localparam int FRAC = 3;
   localparam logic [2:0] ADDR_QSEL = 3'd0;

   typedef struct {
      logic [15:0] word;
      logic last;
   } word_type;

   word_type expected_words[$];
   logic [8:0] qstore[64];
   logic [5:0] load_cnt;
   logic [15:0] pack_buf;
   int pack_cnt;
   logic qsel;

   assign pending = expected_words.size();

   task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   task automatic put_bits(input logic [15:0] data, input int len);
      word_type w;
      for (int i = len - 1; i >= 0; i--) begin
         pack_buf = {pack_buf[14:0], data[i]};
         pack_cnt++;
         if (pack_cnt == 16) begin
            w.word = pack_buf;
            w.last = 1'b0;
            expected_words.push_back(w);
            pack_cnt = 0;
         end
      end
   endtask

   function automatic logic [8:0] quantize(input logic [15:0] v, input int rc);
      int mag, s, r;
      mag = v[15] ? 65536 - int'(v) : int'(v);
      s = FRAC + bqe_pkg::SHIFT_TAB[qsel][rc];
      r = (mag + (1 << (s - 1))) >> s;
      if (v[15]) return (r > 256) ? bqe_pkg::Q_NEG_MIN : 9'(-r);
      return (r > 255) ? bqe_pkg::Q_POS_MAX : 9'(r);
   endfunction

   function automatic bit is_short(input int v);
      return v < 4 && v >= -4;
   endfunction

   task automatic encode_block();
      int q[64];
      int j, run;
      logic [8:0] u;
      run = 0;
      for (int k = 0; k < 64; k++) begin
         u = qstore[bqe_pkg::ZZ_ORDER[k]];
         q[k] = u[8] ? int'(u) - 512 : int'(u);
      end
      for (int k = 0; k < 64; k++) begin
         if (q[k] == 0) begin
            for (j = k + 1; j < 64; j++)
               if (q[j] != 0) break;
            if (j == 64) begin
               put_bits(16'(bqe_pkg::CODE_EOB), 4);
               break;
            end else if (run == 7) begin
               run = 0;
               put_bits(16'(bqe_pkg::CODE_RUN), 2);
               put_bits(16'd0, 3);
            end else begin
               run++;
            end
         end else begin
            if (run != 0) begin
               put_bits(16'(bqe_pkg::CODE_RUN), 2);
               put_bits(16'(run & 7), 3);
               run = 0;
            end
            if (is_short(q[k])) begin
               if (k + 1 < 64 && is_short(q[k+1]) &&
                   !(q[k+1] == 0 && k + 2 < 64 && q[k+2] == 0)) begin
                  put_bits(16'(bqe_pkg::CODE_PAIR), 2);
                  put_bits(16'(q[k] & 7), 3);
                  k++;
                  put_bits(16'(q[k] & 7), 3);
               end else begin
                  put_bits(16'(bqe_pkg::CODE_SHORT), 2);
                  put_bits(16'(q[k] & 7), 3);
               end
            end else if (q[k] < 32 && q[k] >= -32) begin
               put_bits(16'(bqe_pkg::CODE_MEDIUM), 3);
               put_bits(16'(q[k] & 'h3f), 6);
            end else begin
               put_bits(16'(bqe_pkg::CODE_LONG), 4);
               put_bits(16'(q[k] & 'h1ff), 9);
            end
         end
      end
   endtask

   task automatic predict_request(input logic func, input logic [15:0] coeff);
      int before_n;
      before_n = expected_words.size();
      if (func == bqe_pkg::FUNC_FLUSH) begin
         put_bits(16'd0, 15);
      end else begin
         qstore[load_cnt] = quantize(coeff, int'(load_cnt[5:3]) + int'(load_cnt[2:0]));
         load_cnt = load_cnt + 6'd1;
         if (load_cnt == 6'd0) encode_block();
      end
      if (expected_words.size() > before_n)
         expected_words[expected_words.size()-1].last = 1'b1;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      word_type w;
      if (reset) begin
         expected_words.delete();
         load_cnt = '0;
         pack_buf = '0;
         pack_cnt = 0;
         qsel = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               report("unexpected word", rsp_tdata, 16'h0);
            end else begin
               w = expected_words.pop_front();
               if (rsp_tdata !== w.word) report("out_word", rsp_tdata, w.word);
               if (rsp_tlast !== w.last) report("last_word", 16'(rsp_tlast), 16'(w.last));
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == ADDR_QSEL)
            qsel = csr_pwdata[0];
         if (req_tvalid && req_tready)
            predict_request(req_tuser, req_tdata);
      end
   end
endmodule

// ===== tb/tb_block_quantize_entropy_encode.sv =====
`timescale 1ns / 1ps
// stimulus and verdict for the quantizing zigzag coefficient coder
// depends on bqe_pkg, block_quantize_entropy_encode and bqe_checker
module tb_block_quantize_entropy_encode;

   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_WAIT = 400;
   localparam logic [2:0] ADDR_QSEL = 3'd0;
   localparam int STYLE_EDGE = 0;
   localparam int STYLE_SPARSE = 1;
   localparam int STYLE_DENSE = 2;
   localparam int STYLE_TAIL = 3;
   localparam int STYLE_ZERO = 4;

   logic clock = 0;
   logic reset = 1;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;
   logic req_tvalid = 0, req_tready;
   logic [15:0] req_tdata = '0;
   logic req_tuser = 0;
   logic rsp_tvalid, rsp_tready = 0, rsp_tlast;
   logic [15:0] rsp_tdata;
   int fail_count, pending;
   int burst_left = 0;
   int idle_cycles = 0;
   logic hold_start = 0;

   block_quantize_entropy_encode dut (.*);

   bqe_checker checker_i (.*);

   initial forever #5 clock = ~clock;

   always @(posedge clock)
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_psel && csr_penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("tb_block_quantize_entropy_encode NOT OK");
      $finish;
   end

   // receiver: random stall patterns, one long hold-off over the second block
   initial begin
      int mode;
      repeat (6) @(negedge clock);
      while (!hold_start) @(negedge clock) rsp_tready <= ($urandom_range(0, 3) != 0);
      repeat (300) @(negedge clock) rsp_tready <= 1'b0;
      forever begin
         mode = $urandom_range(0, 2);
         repeat ($urandom_range(8, 48)) @(negedge clock)
            rsp_tready <= (mode == 0) ? 1'b1 : (mode == 1) ? ($urandom_range(0, 3) != 0)
                                                           : $urandom_range(0, 1);
      end
   end

   task automatic csr_write(input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_paddr <= ADDR_QSEL; csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   // caller is at a falling edge
   task automatic send_request(input logic func, input logic [15:0] data);
      if (burst_left == 0) begin
         if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid <= 1; req_tuser <= func; req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      burst_left--;
   endtask

   function automatic logic [15:0] coeff_for(input int style, input int idx);
      int r;
      case (style)
         STYLE_EDGE: begin
            case (idx)
               0: return 16'h7fff;
               1: return 16'h8000;
               2: return 16'd32;
               8: return -16'sd16;
               9: return 16'd40;
               3: return 16'd31;
               17: return -16'sd1000;
               default: return (idx < 30 && idx % 5 == 0) ? 16'(idx * 64) : 16'h0;
            endcase
         end
         STYLE_ZERO: return 16'h0;
         STYLE_TAIL: if (idx == 63) return 16'h7fff;
         default: ;
      endcase
      r = $urandom_range(0, 9);
      if (style == STYLE_SPARSE && r < 6) return 16'h0;
      if (r < 3) return 16'h0;
      if (r < 6) return 16'($signed($urandom_range(0, 1200)) - 600);
      if (r < 8) return 16'(($signed($urandom_range(0, 7)) - 4) * 64);
      if (r < 9) return 16'($urandom);
      return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
   endfunction

   task automatic send_block(input int style);
      for (int i = 0; i < 64; i++) begin
         if (style != STYLE_EDGE && $urandom_range(0, 19) == 0)
            send_request(bqe_pkg::FUNC_FLUSH, 16'($urandom));
         send_request(1'b0, coeff_for(style, i));
      end
   endtask

   // caller is at a falling edge
   task automatic drain();
      req_tvalid <= 0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      csr_write(32'd0);
      send_request(bqe_pkg::FUNC_FLUSH, 16'hffff);
      send_request(bqe_pkg::FUNC_FLUSH, 16'h0000);
      send_block(STYLE_EDGE);
      drain();
      csr_write(32'hffff_ffff);
      hold_start = 1'b1;
      send_block(STYLE_DENSE);
      repeat (3) send_request(bqe_pkg::FUNC_FLUSH, 16'($urandom));
      drain();
      if (fail_count == 0 && pending == 0)
         $display("tb_block_quantize_entropy_encode OK");
      else
         $display("tb_block_quantize_entropy_encode NOT OK");
      $finish;
   end
endmodule
